// ===== rtl/timed_cubic_trajectory_pd_controller_macros.svh =====
// Assertion macros for the cubic trajectory PD servo.
// Used by modules with clock aclk and active-low reset aresetn.
`ifndef TIMED_CUBIC_TRAJECTORY_PD_CONTROLLER_MACROS_SVH
`define TIMED_CUBIC_TRAJECTORY_PD_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctpd_pkg.sv =====
// Shared types, widths and codes for the cubic trajectory PD servo.
// No dependencies.
package ctpd_pkg;

    localparam int JOINT_COUNT = 2;
    localparam int JOINTS_USED = (JOINT_COUNT < 2) ? JOINT_COUNT : 2;
    localparam int LANES       = 2;

    localparam int TIME_W  = 32;
    localparam int DUR_W   = 24;
    localparam int POSE_W  = 32;
    localparam int ANG_W   = 16;
    localparam int RATE_W  = 20;
    localparam int GAIN_W  = 16;
    localparam int TRQ_W   = 32;
    localparam int FRAC_W  = 24;
    localparam int S_W     = FRAC_W + 1;
    localparam int PROD_W  = ANG_W + 1 + S_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W   = 5;
    localparam int S_DIV_STEPS    = FRAC_W;
    localparam int RATE_DIV_STEPS = RATE_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIME    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_SWING  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_SWING = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_POSE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDDLE_POSE  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_POSE     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_POS_GAIN     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_GAIN    = 3'd7;

    typedef enum logic [1:0] {
        PH_HOLD   = 2'd0,
        PH_SWING1 = 2'd1,
        PH_SWING2 = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_PROF, ST_LANE, ST_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        PF_IDLE, PF_DIV, PF_MUL1, PF_MUL2, PF_DONE
    } prof_state_t;

    typedef enum logic [2:0] {
        LN_IDLE, LN_MUL, LN_PREP, LN_DIV, LN_RATE, LN_TMUL, LN_TSUM, LN_DONE
    } lane_state_t;

    // Blend h, g, dur and swing from the profile unit to every lane.
    typedef struct packed {
        logic [S_W-1:0]   h;
        logic [S_W-1:0]   g;
        logic [DUR_W-1:0] dur;
        logic             swing;
    } prof_res_t;

    // What one lane found for its joint.
    typedef struct packed {
        logic signed [TRQ_W-1:0]  torque;
        logic signed [ANG_W-1:0]  qref;
        logic signed [RATE_W-1:0] rref;
    } lane_res_t;

endpackage

// ===== rtl/timed_cubic_trajectory_pd_controller.sv =====
// Top level of the cubic trajectory PD servo: config registers, phase tracking,
// profile unit, joint lanes and the output register. Depends on ctpd_pkg,
// ctpd_profile, ctpd_lane and the macros header.
//
// Usage:
//  - Input channel s_*: one word per control tick (time, joint angles and rates).
//  - Result channel m_*: one word per tick (torques, reference angles and rates,
//    phase). Both channels use valid/ready.
//  - Config port cfg_*: write cfg_wdata to register cfg_addr when cfg_we is high;
//    write only while the block is idle.
//  - Path: an accepted tick passes through the 24-step divider that forms s,
//    then the 20-step per-lane rate divider, before m_valid rises.
//  - Flow: s_ready is high only while no tick is in flight, so a new tick waits
//    until the last one is finished; a finished word waits in the output register,
//    so a new tick may start while the receiver holds m_ready low.
//  - Reset: config registers return to their defaults, phase to hold, both
//    channels empty.
//  - Stall: when the receiver stalls with a word already held, the finished
//    result waits in the lanes and the block takes no new tick.
`include "timed_cubic_trajectory_pd_controller_macros.svh"

module timed_cubic_trajectory_pd_controller import ctpd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [TIME_W-1:0]        s_time_now,
    input  logic signed [ANG_W-1:0]  s_angle_joint0,
    input  logic signed [ANG_W-1:0]  s_angle_joint1,
    input  logic signed [RATE_W-1:0] s_rate_joint0,
    input  logic signed [RATE_W-1:0] s_rate_joint1,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TRQ_W-1:0]  m_torque_joint0,
    output logic signed [TRQ_W-1:0]  m_torque_joint1,
    output logic signed [ANG_W-1:0]  m_ref_angle_joint0,
    output logic signed [ANG_W-1:0]  m_ref_angle_joint1,
    output logic signed [RATE_W-1:0] m_ref_rate_joint0,
    output logic signed [RATE_W-1:0] m_ref_rate_joint1,
    output logic [1:0]               m_phase_now,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

    // Configuration registers.
    logic [DUR_W-1:0]  hold_time_reg;
    logic [DUR_W-1:0]  first_swing_reg;
    logic [DUR_W-1:0]  second_swing_reg;
    logic [POSE_W-1:0] start_pose_reg;
    logic [POSE_W-1:0] middle_pose_reg;
    logic [POSE_W-1:0] end_pose_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] kv_reg;

    top_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic signed [ANG_W-1:0]  angle_reg [LANES];
    logic signed [RATE_W-1:0] rate_reg  [LANES];

    logic                     m_valid_reg;
    logic signed [TRQ_W-1:0]  torque_out_reg [LANES];
    logic signed [ANG_W-1:0]  qref_out_reg   [LANES];
    logic signed [RATE_W-1:0] rref_out_reg   [LANES];
    logic [1:0]               phase_out_reg;

    logic              accept;
    logic              load_out;
    logic [DUR_W:0]    end1;
    logic [DUR_W+1:0]  end2;
    logic [POSE_W-1:0] p0_pose;
    logic [POSE_W-1:0] pf_pose;
    prof_res_t         prof_res;
    logic              prof_done;
    lane_res_t         lane_res [LANES];
    logic [LANES-1:0]  lane_done;

    // Write config registers; unknown indexes have no effect.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg    <= DUR_W'(32768);
            first_swing_reg  <= DUR_W'(65536);
            second_swing_reg <= DUR_W'(65536);
            start_pose_reg   <= 32'h0000_F000;
            middle_pose_reg  <= 32'hE000_0800;
            end_pose_reg     <= 32'h0000_1000;
            kp_reg           <= GAIN_W'(8000);
            kv_reg           <= GAIN_W'(800);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_HOLD_TIME:    hold_time_reg    <= cfg_wdata[DUR_W-1:0];
                CFG_FIRST_SWING:  first_swing_reg  <= cfg_wdata[DUR_W-1:0];
                CFG_SECOND_SWING: second_swing_reg <= cfg_wdata[DUR_W-1:0];
                CFG_START_POSE:   start_pose_reg   <= cfg_wdata[POSE_W-1:0];
                CFG_MIDDLE_POSE:  middle_pose_reg  <= cfg_wdata[POSE_W-1:0];
                CFG_END_POSE:     end_pose_reg     <= cfg_wdata[POSE_W-1:0];
                CFG_POS_GAIN:     kp_reg           <= cfg_wdata[GAIN_W-1:0];
                CFG_RATE_GAIN:    kv_reg           <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the phase as far as the new time allows; never step back.
    always_comb begin
        end1       = {1'b0, hold_time_reg} + {1'b0, first_swing_reg};
        end2       = {1'b0, end1} + {2'b00, second_swing_reg};
        phase_next = phase_reg;
        if (phase_next == PH_HOLD &&
            s_time_now >= {{(TIME_W-DUR_W){1'b0}}, hold_time_reg}) begin
            phase_next = PH_SWING1;
        end
        if (phase_next == PH_SWING1 &&
            s_time_now >= {{(TIME_W-DUR_W-1){1'b0}}, end1}) begin
            phase_next = PH_SWING2;
        end
        if (phase_next == PH_SWING2 &&
            s_time_now >= {{(TIME_W-DUR_W-2){1'b0}}, end2}) begin
            phase_next = PH_STOP;
        end
    end

    // Poses at both ends of the current segment.
    always_comb begin
        case (phase_reg)
            PH_SWING1: begin
                p0_pose = start_pose_reg;
                pf_pose = middle_pose_reg;
            end
            PH_SWING2: begin
                p0_pose = middle_pose_reg;
                pf_pose = end_pose_reg;
            end
            PH_STOP: begin
                p0_pose = end_pose_reg;
                pf_pose = end_pose_reg;
            end
            default: begin
                p0_pose = start_pose_reg;
                pf_pose = start_pose_reg;
            end
        endcase
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept)     state_next = ST_PROF;
            ST_PROF: if (prof_done)  state_next = ST_LANE;
            ST_LANE: if (&lane_done) state_next = ST_DONE;
            ST_DONE: if (load_out)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        accept   = s_valid && s_ready;
        load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_HOLD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                phase_reg <= phase_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the measured values for the lanes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            angle_reg[0] <= s_angle_joint0;
            angle_reg[1] <= s_angle_joint1;
            rate_reg[0]  <= s_rate_joint0;
            rate_reg[1]  <= s_rate_joint1;
        end
    end

    ctpd_profile u_profile (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (accept),
        .time_now          (s_time_now),
        .phase             (phase_next),
        .hold_time         (hold_time_reg),
        .first_swing_time  (first_swing_reg),
        .second_swing_time (second_swing_reg),
        .res               (prof_res),
        .done              (prof_done)
    );

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        ctpd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (prof_done),
            .prof    (prof_res),
            .q0      (p0_pose[ANG_W*j +: ANG_W]),
            .qf      (pf_pose[ANG_W*j +: ANG_W]),
            .q       (angle_reg[j]),
            .qd      (rate_reg[j]),
            .kp      (kp_reg),
            .kv      (kv_reg),
            .res     (lane_res[j]),
            .done    (lane_done[j])
        );

        // Merge: joints past the configured count report zero.
        always_ff @(posedge aclk) begin
            if (load_out) begin
                if (j < JOINTS_USED) begin
                    torque_out_reg[j] <= lane_res[j].torque;
                    qref_out_reg[j]   <= lane_res[j].qref;
                    rref_out_reg[j]   <= lane_res[j].rref;
                end else begin
                    torque_out_reg[j] <= '0;
                    qref_out_reg[j]   <= '0;
                    rref_out_reg[j]   <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            phase_out_reg <= phase_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_torque_joint0    = torque_out_reg[0];
    assign m_torque_joint1    = torque_out_reg[1];
    assign m_ref_angle_joint0 = qref_out_reg[0];
    assign m_ref_angle_joint1 = qref_out_reg[1];
    assign m_ref_rate_joint0  = rref_out_reg[0];
    assign m_ref_rate_joint1  = rref_out_reg[1];
    assign m_phase_now        = phase_out_reg;

    `CTPD_ASSERT_NEXT(a_phase_monotonic, accept, phase_reg >= $past(phase_reg), "phase went back")
    `CTPD_ASSERT_NOW(a_lanes_in_step, |lane_done, &lane_done, "lanes finished apart")
    `CTPD_ASSERT_NOW(a_prof_done_state, prof_done, state_reg == ST_PROF, "profile done while not waiting")
    `CTPD_ASSERT_NEXT(a_load_sets_valid, load_out, m_valid && state_reg == ST_IDLE, "result load lost")

endmodule

// ===== rtl/ctpd_profile.sv =====
// Shared profile unit: relative time, normalized time s, blend h and rate factor g.
// Depends on ctpd_pkg.
`include "timed_cubic_trajectory_pd_controller_macros.svh"

module ctpd_profile import ctpd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [TIME_W-1:0]  time_now,
    input  phase_t             phase,
    input  logic [DUR_W-1:0]   hold_time,
    input  logic [DUR_W-1:0]   first_swing_time,
    input  logic [DUR_W-1:0]   second_swing_time,
    output prof_res_t          res,
    output logic               done
);

    localparam logic [S_W-1:0] ONE24 = S_W'(1) << FRAC_W;

    prof_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [DUR_W-1:0]  rem_reg;
    logic [DUR_W-1:0]  quot_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              swing_reg;
    logic              full_reg;
    logic [S_W-1:0]    s_reg;
    logic [S_W-1:0]    s2_reg;
    logic [2*S_W-4:0]  sg_reg;
    logic [S_W-1:0]    h_reg;
    logic [S_W-1:0]    g_reg;

    logic [DUR_W:0]    end1;
    logic [DUR_W:0]    t0;
    logic [DUR_W-1:0]  dur;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] tau_raw;
    logic [DUR_W-1:0]  tau;
    logic              swing;
    logic [DUR_W:0]    rem_sh;
    logic [S_W-1:0]    s_val;
    logic [2*S_W-1:0]  s2_prod;
    logic [2*S_W-1:0]  sg_prod;
    logic [S_W:0]      blend_m;
    logic [2*S_W:0]    h_prod;
    logic [2*S_W-1:0]  g_six;

    // Window of the current swing.
    always_comb begin
        end1  = {1'b0, hold_time} + {1'b0, first_swing_time};
        swing = (phase == PH_SWING1) || (phase == PH_SWING2);
        t0    = '0;
        dur   = '0;
        case (phase)
            PH_SWING1: begin
                t0  = {1'b0, hold_time};
                dur = first_swing_time;
            end
            PH_SWING2: begin
                t0  = end1;
                dur = second_swing_time;
            end
            default: ;
        endcase
        diff    = {1'b0, time_now} - {{(TIME_W-DUR_W){1'b0}}, t0};
        tau_raw = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
        tau     = (tau_raw > {{(TIME_W-DUR_W){1'b0}}, dur}) ? dur : tau_raw[DUR_W-1:0];
    end

    always_comb begin
        rem_sh  = {rem_reg, 1'b0};
        s_val   = full_reg ? ONE24 : {1'b0, quot_reg};
        s2_prod = s_val * s_val;
        sg_prod = s_val * (ONE24 - s_val);
        blend_m = ({1'b0, ONE24} + {ONE24, 1'b0}) - {s_reg, 1'b0};
        h_prod  = s2_reg * blend_m;
        g_six   = {1'b0, sg_reg, 2'b00} + {2'b00, sg_reg, 1'b0};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PF_IDLE: if (start) state_next = PF_DIV;
            PF_DIV:  if (cnt_reg == CNT_W'(S_DIV_STEPS - 1)) state_next = PF_MUL1;
            PF_MUL1: state_next = PF_MUL2;
            PF_MUL2: state_next = PF_DONE;
            PF_DONE: state_next = PF_IDLE;
            default: state_next = PF_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == PF_DONE);
        res  = '{h: h_reg, g: g_reg, dur: dur_reg, swing: swing_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PF_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            PF_IDLE: begin
                if (start) begin
                    rem_reg   <= tau;
                    quot_reg  <= '0;
                    cnt_reg   <= '0;
                    dur_reg   <= dur;
                    swing_reg <= swing;
                    full_reg  <= (tau == dur);
                end
            end
            PF_DIV: begin
                // One quotient bit per cycle; tau <= dur so the remainder stays narrow.
                if (rem_sh >= {1'b0, dur_reg}) begin
                    rem_reg  <= DUR_W'(rem_sh - {1'b0, dur_reg});
                    quot_reg <= {quot_reg[DUR_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh[DUR_W-1:0];
                    quot_reg <= {quot_reg[DUR_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            PF_MUL1: begin
                s_reg  <= s_val;
                s2_reg <= s2_prod[FRAC_W+S_W-1:FRAC_W];
                sg_reg <= sg_prod[2*S_W-4:0];
            end
            PF_MUL2: begin
                h_reg <= h_prod[FRAC_W+S_W-1:FRAC_W];
                g_reg <= g_six[FRAC_W+S_W-1:FRAC_W];
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/ctpd_lane.sv =====
// One joint lane: reference angle, reference rate divider and PD torque.
// Depends on ctpd_pkg.
module ctpd_lane import ctpd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  prof_res_t                prof,
    input  logic signed [ANG_W-1:0]  q0,
    input  logic signed [ANG_W-1:0]  qf,
    input  logic signed [ANG_W-1:0]  q,
    input  logic signed [RATE_W-1:0] qd,
    input  logic [GAIN_W-1:0]        kp,
    input  logic [GAIN_W-1:0]        kv,
    output lane_res_t                res,
    output logic                     done
);

    localparam int DIVD_W = PROD_W + 1;
    localparam int REM_W  = DUR_W + 8;
    localparam int CMP_W  = DUR_W + 28;

    lane_state_t state_reg, state_next;

    logic signed [PROD_W-1:0] ph_reg;
    logic signed [PROD_W-1:0] num_reg;
    logic signed [ANG_W-1:0]  qref_reg;
    logic signed [RATE_W-1:0] rref_reg;
    logic signed [TRQ_W-1:0]  torque_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [RATE_W-1:0]        dlo_reg;
    logic [RATE_W-1:0]        quot_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ovf_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic signed [GAIN_W+ANG_W+1:0]  p1_reg;
    logic signed [GAIN_W+RATE_W+1:0] p2_reg;

    logic signed [ANG_W:0]    dq;
    logic signed [PROD_W-1:0] ph_rnd;
    logic signed [PROD_W-1:0] ph_sh;
    logic signed [ANG_W+2:0]  qsum;
    logic signed [ANG_W-1:0]  qref_sat;
    logic [PROD_W-1:0]        mag;
    logic [DIVD_W-1:0]        div_d;
    logic [REM_W:0]           rs;
    logic [REM_W:0]           den;
    logic signed [RATE_W-1:0] rref_calc;
    logic signed [ANG_W:0]    e1;
    logic signed [RATE_W:0]   e2;
    logic signed [GAIN_W+RATE_W+2:0] acc;
    logic signed [GAIN_W+RATE_W+3:0] nacc;

    always_comb begin
        dq     = {qf[ANG_W-1], qf} - {q0[ANG_W-1], q0};
        ph_rnd = ph_reg + (PROD_W'(1) <<< (FRAC_W - 1));
        ph_sh  = ph_rnd >>> FRAC_W;
        qsum   = {{3{q0[ANG_W-1]}}, q0} + ph_sh[ANG_W+2:0];
        if (qsum > (ANG_W+3)'(32767)) begin
            qref_sat = 16'sh7FFF;
        end else if (qsum < -(ANG_W+3)'(32768)) begin
            qref_sat = 16'sh8000;
        end else begin
            qref_sat = qsum[ANG_W-1:0];
        end
        mag   = num_reg[PROD_W-1] ? PROD_W'(-num_reg) : num_reg;
        div_d = {1'b0, mag} + {{(DIVD_W-DUR_W-7){1'b0}}, prof.dur, 7'b0};
        rs    = {rem_reg, dlo_reg[RATE_W-1]};
        den   = {1'b0, prof.dur, 8'b0};
        // Round half away from zero, then clamp to the rate range.
        if (zero_reg) begin
            rref_calc = '0;
        end else if (!neg_reg) begin
            rref_calc = (ovf_reg || quot_reg[RATE_W-1]) ? {1'b0, {(RATE_W-1){1'b1}}}
                                                        : quot_reg;
        end else begin
            rref_calc = (ovf_reg || quot_reg > {1'b1, {(RATE_W-1){1'b0}}})
                        ? {1'b1, {(RATE_W-1){1'b0}}} : RATE_W'(-quot_reg);
        end
        e1   = {q[ANG_W-1], q} - {qref_reg[ANG_W-1], qref_reg};
        e2   = {qd[RATE_W-1], qd} - {rref_reg[RATE_W-1], rref_reg};
        acc  = p1_reg + p2_reg;
        nacc = -acc + (GAIN_W+RATE_W+4)'(128);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE: if (start) state_next = LN_MUL;
            LN_MUL:  state_next = LN_PREP;
            LN_PREP: state_next = LN_DIV;
            LN_DIV:  if (cnt_reg == CNT_W'(RATE_DIV_STEPS - 1)) state_next = LN_RATE;
            LN_RATE: state_next = LN_TMUL;
            LN_TMUL: state_next = LN_TSUM;
            LN_TSUM: state_next = LN_DONE;
            LN_DONE: state_next = LN_IDLE;
            default: state_next = LN_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == LN_DONE);
        res  = '{torque: torque_reg, qref: qref_reg, rref: rref_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LN_MUL: begin
                ph_reg  <= dq * $signed({1'b0, prof.h});
                num_reg <= dq * $signed({1'b0, prof.g});
            end
            LN_PREP: begin
                qref_reg <= prof.swing ? qref_sat : q0;
                rem_reg  <= REM_W'(div_d[DIVD_W-1:RATE_W]);
                dlo_reg  <= div_d[RATE_W-1:0];
                ovf_reg  <= {{(CMP_W-DIVD_W){1'b0}}, div_d} >= {prof.dur, 28'b0};
                neg_reg  <= num_reg[PROD_W-1];
                zero_reg <= !prof.swing || (prof.dur == '0);
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            LN_DIV: begin
                if (rs >= den) begin
                    rem_reg  <= REM_W'(rs - den);
                    quot_reg <= {quot_reg[RATE_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rs[REM_W-1:0];
                    quot_reg <= {quot_reg[RATE_W-2:0], 1'b0};
                end
                dlo_reg <= {dlo_reg[RATE_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            LN_RATE: rref_reg <= rref_calc;
            LN_TMUL: begin
                p1_reg <= $signed({1'b0, kp}) * e1;
                p2_reg <= $signed({1'b0, kv}) * e2;
            end
            LN_TSUM: begin
                // |acc| stays below 2^37, so the shifted value always fits 32 bits.
                torque_reg <= nacc[TRQ_W+7:8];
            end
            default: ;
        endcase
    end

endmodule

// ===== test/timed_cubic_trajectory_pd_controller_tb.sv =====
// Self-checking testbench for the cubic trajectory PD servo: drives control ticks,
// predicts every result word and compares it. Depends on ctpd_pkg and the top level.
// Single file, top module last.
module timed_cubic_trajectory_pd_controller_tb;
    import ctpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q24 = longint'(1) << 24;

    // One result word as the block should present it.
    typedef struct {
        logic signed [TRQ_W-1:0]  trq  [2];
        logic signed [ANG_W-1:0]  qref [2];
        logic signed [RATE_W-1:0] rref [2];
        phase_t                   ph;
    } servo_word_t;

    // Servo predictor plus the queue of words still owed by the block.
    class servo_scoreboard;
        logic [DUR_W-1:0]  hold_t, swing1_t, swing2_t;
        logic [POSE_W-1:0] pose_start, pose_mid, pose_end;
        logic [GAIN_W-1:0] kp, kv;
        phase_t            phase;
        servo_word_t       owed [$];
        int                mismatches;
        int                words_seen;
        int                phase_hits [4];

        function void reset_state();
            hold_t     = 24'd32768;
            swing1_t   = 24'd65536;
            swing2_t   = 24'd65536;
            pose_start = 32'h0000_F000;
            pose_mid   = 32'hE000_0800;
            pose_end   = 32'h0000_1000;
            kp         = 16'd8000;
            kv         = 16'd800;
            phase      = PH_HOLD;
            mismatches = 0;
            words_seen = 0;
            foreach (phase_hits[i]) phase_hits[i] = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_HOLD_TIME:    hold_t     = v[DUR_W-1:0];
                CFG_FIRST_SWING:  swing1_t   = v[DUR_W-1:0];
                CFG_SECOND_SWING: swing2_t   = v[DUR_W-1:0];
                CFG_START_POSE:   pose_start = v;
                CFG_MIDDLE_POSE:  pose_mid   = v;
                CFG_END_POSE:     pose_end   = v;
                CFG_POS_GAIN:     kp         = v[GAIN_W-1:0];
                CFG_RATE_GAIN:    kv         = v[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint x, int w);
            longint hi, lo;
            hi = (longint'(1) << (w - 1)) - 1;
            lo = -hi - 1;
            return (x > hi) ? hi : ((x < lo) ? lo : x);
        endfunction

        function longint end_swing1();
            return longint'(hold_t) + longint'(swing1_t);
        endfunction

        function longint end_swing2();
            return end_swing1() + longint'(swing2_t);
        endfunction

        // Advance the phase for one tick and queue the word it must produce.
        function void note_tick(logic [TIME_W-1:0] t_now,
                                logic signed [ANG_W-1:0] a0, logic signed [ANG_W-1:0] a1,
                                logic signed [RATE_W-1:0] r0, logic signed [RATE_W-1:0] r1);
            longint t, t0, dur, tau, s, s2, h, g, q0, qf, q, qd, dq, qref, rref;
            longint num, den, mag, r, acc;
            logic [POSE_W-1:0] p0, pf;
            logic signed [ANG_W-1:0]  ang [2];
            logic signed [RATE_W-1:0] rat [2];
            bit swinging;
            servo_word_t w;
            t = longint'(t_now);
            ang[0] = a0; ang[1] = a1; rat[0] = r0; rat[1] = r1;
            // phase only moves forward, possibly several steps at once
            if (phase == PH_HOLD && t >= longint'(hold_t)) phase = PH_SWING1;
            if (phase == PH_SWING1 && t >= end_swing1()) phase = PH_SWING2;
            if (phase == PH_SWING2 && t >= end_swing2()) phase = PH_STOP;
            t0 = 0; dur = 0; p0 = pose_start; pf = pose_start;
            case (phase)
                PH_SWING1: begin
                    t0 = hold_t; dur = swing1_t; p0 = pose_start; pf = pose_mid;
                end
                PH_SWING2: begin
                    t0 = end_swing1(); dur = swing2_t; p0 = pose_mid; pf = pose_end;
                end
                PH_STOP: begin
                    p0 = pose_end; pf = pose_end;
                end
                default: ;
            endcase
            swinging = (phase == PH_SWING1) || (phase == PH_SWING2);
            h = 0; g = 0;
            if (swinging) begin
                tau = (t >= t0) ? t - t0 : 0;
                if (tau > dur) tau = dur;
                s  = (dur == 0) ? ONE_Q24 : (tau << 24) / dur;
                s2 = (s * s) >>> 24;
                h  = (s2 * (3 * ONE_Q24 - 2 * s)) >>> 24;
                g  = (6 * s * (ONE_Q24 - s)) >>> 24;
            end
            for (int j = 0; j < 2; j++) begin
                qref = 0; rref = 0;
                if (j < JOINTS_USED) begin
                    q0 = longint'($signed(p0[16*j +: 16]));
                    qf = longint'($signed(pf[16*j +: 16]));
                    q  = longint'(ang[j]);
                    qd = longint'(rat[j]);
                    qref = q0;
                    if (swinging) begin
                        dq = qf - q0;
                        qref = clip(q0 + ((dq * h + (longint'(1) << 23)) >>> 24), ANG_W);
                        if (dur != 0) begin
                            num = dq * g;
                            den = dur << 8;
                            mag = (num < 0) ? -num : num;
                            r = (mag + den / 2) / den;
                            rref = clip((num < 0) ? -r : r, RATE_W);
                        end
                    end
                    acc = longint'(kp) * (q - qref) + longint'(kv) * (qd - rref);
                    w.trq[j] = TRQ_W'(clip((-acc + 128) >>> 8, TRQ_W));
                end else begin
                    w.trq[j] = '0;
                end
                w.qref[j] = ANG_W'(qref);
                w.rref[j] = RATE_W'(rref);
            end
            w.ph = phase;
            phase_hits[phase]++;
            owed.push_back(w);
        endfunction

        // Compare a word from the block with the oldest one still owed.
        function void check_word(servo_word_t got);
            servo_word_t want;
            words_seen++;
            if (owed.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            for (int j = 0; j < 2; j++) begin
                if (got.trq[j] !== want.trq[j]) begin
                    $display("%0t: torque_joint%0d expected %0d actual %0d",
                             $time, j, want.trq[j], got.trq[j]);
                    mismatches++;
                end
                if (got.qref[j] !== want.qref[j]) begin
                    $display("%0t: ref_angle_joint%0d expected %0d actual %0d",
                             $time, j, want.qref[j], got.qref[j]);
                    mismatches++;
                end
                if (got.rref[j] !== want.rref[j]) begin
                    $display("%0t: ref_rate_joint%0d expected %0d actual %0d",
                             $time, j, want.rref[j], got.rref[j]);
                    mismatches++;
                end
            end
            if (got.ph !== want.ph) begin
                $display("%0t: phase_now expected %0d actual %0d", $time, want.ph, got.ph);
                mismatches++;
            end
        endfunction

        function int owed_count();
            return owed.size();
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [TIME_W-1:0]        s_time_now = '0;
    logic signed [ANG_W-1:0]  s_angle_joint0 = '0;
    logic signed [ANG_W-1:0]  s_angle_joint1 = '0;
    logic signed [RATE_W-1:0] s_rate_joint0 = '0;
    logic signed [RATE_W-1:0] s_rate_joint1 = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [TRQ_W-1:0]  m_torque_joint0, m_torque_joint1;
    logic signed [ANG_W-1:0]  m_ref_angle_joint0, m_ref_angle_joint1;
    logic signed [RATE_W-1:0] m_ref_rate_joint0, m_ref_rate_joint1;
    logic [1:0]               m_phase_now;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    servo_scoreboard sb = new();

    // sender burst bookkeeping
    int burst_left = 0;
    int ticks_sent = 0;
    // receiver: long hold request from the main flow, and the count it works off
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int rx_cycle = 0;

    always #10 aclk = ~aclk;

    timed_cubic_trajectory_pd_controller u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_time_now         (s_time_now),
        .s_angle_joint0     (s_angle_joint0),
        .s_angle_joint1     (s_angle_joint1),
        .s_rate_joint0      (s_rate_joint0),
        .s_rate_joint1      (s_rate_joint1),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_torque_joint0    (m_torque_joint0),
        .m_torque_joint1    (m_torque_joint1),
        .m_ref_angle_joint0 (m_ref_angle_joint0),
        .m_ref_angle_joint1 (m_ref_angle_joint1),
        .m_ref_rate_joint0  (m_ref_rate_joint0),
        .m_ref_rate_joint1  (m_ref_rate_joint1),
        .m_phase_now        (m_phase_now),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata)
    );

    // Receiver: long hold when asked, otherwise alternate clean stretches
    // with stretches of random back-pressure.
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = 400;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_cycle[6]) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check every word the receiver takes.
    always @(posedge aclk) begin
        servo_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got.trq[0]  = m_torque_joint0;
            got.trq[1]  = m_torque_joint1;
            got.qref[0] = m_ref_angle_joint0;
            got.qref[1] = m_ref_angle_joint1;
            got.rref[0] = m_ref_rate_joint0;
            got.rref[1] = m_ref_rate_joint1;
            got.ph      = phase_t'(m_phase_now);
            sb.check_word(got);
        end
    end

    // Offer one tick; hold it until accepted, then note it for prediction.
    // Bursts of random length are separated by random gaps.
    task automatic send_tick(logic [TIME_W-1:0] t,
                             logic signed [ANG_W-1:0] a0, logic signed [ANG_W-1:0] a1,
                             logic signed [RATE_W-1:0] r0, logic signed [RATE_W-1:0] r1);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_time_now     <= t;
        s_angle_joint0 <= a0;
        s_angle_joint1 <= a1;
        s_rate_joint0  <= r0;
        s_rate_joint1  <= r1;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(t, a0, a1, r0, r1);
        ticks_sent++;
    endtask

    // Drop valid and wait until every owed word has arrived, then let the
    // block settle for its pipeline latency.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed_count() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic cfg_close();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [ANG_W-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return ANG_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 20'sh80000;
            1: return 20'sh7FFFF;
            2: return 20'sh00000;
            default: return RATE_W'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    task automatic random_tick(logic [TIME_W-1:0] t);
        send_tick(t, pick_angle(), pick_angle(), pick_rate(), pick_rate());
    endtask

    initial begin
        longint e1, e2;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        sb.reset_state();

        // Hold phase with default registers: field extremes.
        send_tick(32'd0, 16'sh7FFF, 16'sh8000, 20'sh7FFFF, 20'sh80000);
        send_tick(32'd1, 16'sh8000, 16'sh7FFF, 20'sh80000, 20'sh7FFFF);
        send_tick(32'd32767, 16'sh0000, 16'shFFFF, 20'sh00000, 20'shFFFFF);
        send_tick(32'd100, 16'sh7FFF, 16'sh7FFF, 20'sh80000, 20'sh80000);
        send_tick(32'd5, 16'sh8000, 16'sh8000, 20'sh7FFFF, 20'sh7FFFF);

        // First swing at its longest, gains at full scale, later zero and then random.
        drain();
        put_reg(CFG_HOLD_TIME, 32'd4096);
        put_reg(CFG_FIRST_SWING, 32'h00FF_FFFF);
        put_reg(CFG_SECOND_SWING, 32'd1024);
        put_reg(CFG_START_POSE, $urandom());
        put_reg(CFG_MIDDLE_POSE, $urandom());
        put_reg(CFG_END_POSE, $urandom());
        put_reg(CFG_POS_GAIN, 32'hFFFF);
        put_reg(CFG_RATE_GAIN, 32'hFFFF);
        cfg_close();
        random_tick($urandom_range(0, 4095));
        random_tick(32'd4095);
        random_tick(32'd4096);
        random_tick(32'd0);
        e1 = sb.end_swing1();
        send_tick(TIME_W'(e1 - 1), 16'sh7FFF, 16'sh8000, 20'sh7FFFF, 20'sh80000);
        for (int i = 0; i < 190; i++) begin
            // ask for a long receiver hold while the sender keeps offering
            if (i == 40) rx_hold_req = 1'b1;
            if (i == 95) begin
                drain();
                put_reg(CFG_START_POSE, 32'h8000_7FFF);
                put_reg(CFG_MIDDLE_POSE, 32'h7FFF_8000);
                put_reg(CFG_POS_GAIN, 32'd0);
                put_reg(CFG_RATE_GAIN, 32'd0);
                cfg_close();
            end
            if (i == 140) begin
                drain();
                put_reg(CFG_POS_GAIN, CFG_DATA_W'(pick_gain()));
                put_reg(CFG_RATE_GAIN, CFG_DATA_W'(pick_gain()));
                put_reg(CFG_START_POSE, $urandom());
                cfg_close();
            end
            if ($urandom_range(0, 9) == 0) random_tick($urandom_range(0, 4095));
            else random_tick($urandom_range(4096, TIME_W'(e1 - 1)));
        end

        // Second swing: short first to saturate the reference rate.
        random_tick(TIME_W'(e1));
        e2 = sb.end_swing2();
        for (int i = 0; i < 160; i++) begin
            if (i == 80) begin
                drain();
                put_reg(CFG_SECOND_SWING, 32'h0003_FFFF);
                put_reg(CFG_MIDDLE_POSE, $urandom());
                put_reg(CFG_END_POSE, $urandom());
                put_reg(CFG_POS_GAIN, CFG_DATA_W'(pick_gain()));
                put_reg(CFG_RATE_GAIN, CFG_DATA_W'(pick_gain()));
                cfg_close();
                e2 = sb.end_swing2();
            end
            case ($urandom_range(0, 9))
                0: random_tick($urandom_range(0, TIME_W'(e1 - 1)));
                1: random_tick(TIME_W'(e2 - 1));
                default: random_tick($urandom_range(TIME_W'(e1), TIME_W'(e2 - 1)));
            endcase
        end

        // Stop phase, then registers pushed to their extremes.
        random_tick(TIME_W'(e2));
        drain();
        put_reg(CFG_HOLD_TIME, 32'h00FF_FFFF);
        put_reg(CFG_FIRST_SWING, 32'd1);
        put_reg(CFG_SECOND_SWING, 32'd1);
        put_reg(CFG_END_POSE, 32'h8000_7FFF);
        put_reg(CFG_POS_GAIN, 32'hFFFF);
        put_reg(CFG_RATE_GAIN, 32'hFFFF);
        cfg_close();
        random_tick(32'hFFFF_FFFF);
        random_tick(32'd0);
        for (int i = 0; i < 140; i++) begin
            if (i == 70) begin
                drain();
                put_reg(CFG_HOLD_TIME, 32'd1);
                put_reg(CFG_END_POSE, $urandom());
                put_reg(CFG_POS_GAIN, CFG_DATA_W'(pick_gain()));
                put_reg(CFG_RATE_GAIN, CFG_DATA_W'(pick_gain()));
                cfg_close();
            end
            random_tick($urandom());
        end

        drain();
        $display("Sent %0d ticks, checked %0d words (hold %0d, swing1 %0d, swing2 %0d, stop %0d)",
                 ticks_sent, sb.words_seen, sb.phase_hits[0], sb.phase_hits[1],
                 sb.phase_hits[2], sb.phase_hits[3]);
        $display("Covered field extremes, gain extremes, rate saturation and time jumps back.");
        if (sb.mismatches == 0 && sb.owed_count() == 0) begin
            $display("[timed_cubic_trajectory_pd_controller] OK");
        end else begin
            $display("[timed_cubic_trajectory_pd_controller] ERROR");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial begin
        #20ms;
        $display("[timed_cubic_trajectory_pd_controller] ERROR");
        $finish;
    end

endmodule
